// ----- design/wfpr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window frame pixel role: shared package
// Geometry constants, colour role codes, stage payload types and the helper
// that places the title text box vertically.
// ----------------------------------------------------------------------------
package wfpr_pkg;

   // Coordinate width of pixel positions and window sizes.
   localparam int CoordBits = 12;
   localparam int TitleBits = 5;

   // Frame geometry, all in window-local pixels.
   localparam int Border   = 3;
   localparam int Button   = 14;
   localparam int AreaH    = 18;
   localparam int BarH     = Border + AreaH + 1;
   localparam int BtnY     = Border + (AreaH - Button) / 2;
   localparam int CloseX   = Border + 2;
   localparam int MinX     = CloseX + Button + 3;
   localparam int TextX    = MinX + Button + 6;
   localparam int BtnLast  = Button - 1;

   // Colour roles handed on to the theme palette.
   typedef enum logic [3:0] {
      ROLE_DARK           = 4'd0,
      ROLE_HIGH           = 4'd1,
      ROLE_SHADOW         = 4'd2,
      ROLE_LIGHT          = 4'd3,
      ROLE_BUTTON         = 4'd4,
      ROLE_TITLE_ACTIVE   = 4'd5,
      ROLE_TITLE_INACTIVE = 4'd6,
      ROLE_STRIPE_ACTIVE  = 4'd7,
      ROLE_STRIPE_INACT   = 4'd8,
      ROLE_FACE           = 4'd9
   } role_type;

   // Frame region after the priority decision.
   typedef enum logic [3:0] {
      REG_DARK,
      REG_HIGH,
      REG_SHADOW,
      REG_SEP_HIGH,
      REG_SEP_DARK,
      REG_CLOSE,
      REG_MINIMISE,
      REG_BAR,
      REG_FACE
   } region_type;

   // Compare results of the first stage.
   typedef struct packed {
      logic                  edge_dark;
      logic                  edge_high;
      logic                  edge_shadow;
      logic                  span;
      logic                  row_sep_high;
      logic                  row_sep_dark;
      logic                  in_close;
      logic                  in_minimise;
      logic                  in_bar;
      logic                  text_box;
      logic                  stripe;
      logic                  active;
      logic [3:0]            close_bx;
      logic [3:0]            min_bx;
      logic [3:0]            btn_by;
      logic [CoordBits-1:0]  texel_x;
      logic [TitleBits-1:0]  texel_y;
   } decode_type;

   // Region decision of the second stage.
   typedef struct packed {
      region_type            region;
      logic                  stripe;
      logic                  active;
      logic [3:0]            bx;
      logic [3:0]            by;
      logic                  hit;
      logic [CoordBits-1:0]  texel_x;
      logic [TitleBits-1:0]  texel_y;
   } class_type;

   // Result word.
   typedef struct packed {
      logic [3:0]            color_role;
      logic                  title_hit;
      logic [CoordBits-1:0]  texel_x;
      logic [TitleBits-1:0]  texel_y;
   } result_type;

   // Top row of the title text box: centred in the title area, with the
   // halving rounded toward zero, so tall titles start above the area.
   function automatic logic signed [5:0] title_top(logic [TitleBits-1:0] th);
      logic signed [5:0] diff;
      logic signed [5:0] half;
      diff = 6'(AreaH) - $signed({1'b0, th});
      half = (diff + (diff[5] ? 6'sd1 : 6'sd0)) >>> 1;
      return 6'(6'(Border) + half);
   endfunction

endpackage

// ----- design/wfpr_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window frame pixel role: channel interfaces
// Valid/ready channels for the pixel request and the role response.
// ----------------------------------------------------------------------------
interface wfpr_req_if;
   import wfpr_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CoordBits-1:0]  pixel_x;
   logic [CoordBits-1:0]  pixel_y;
   logic [CoordBits-1:0]  win_width;
   logic [CoordBits-1:0]  win_height;
   logic                  is_active;
   logic [CoordBits-1:0]  title_width;
   logic [TitleBits-1:0]  title_height;

   modport source (output valid, pixel_x, pixel_y, win_width, win_height,
                   is_active, title_width, title_height, input ready);
   modport sink   (input valid, pixel_x, pixel_y, win_width, win_height,
                   is_active, title_width, title_height, output ready);
endinterface

interface wfpr_rsp_if;
   import wfpr_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [3:0]            color_role;
   logic                  title_hit;
   logic [CoordBits-1:0]  texel_x;
   logic [TitleBits-1:0]  texel_y;

   modport source (output valid, color_role, title_hit, texel_x, texel_y,
                   input ready);
   modport sink   (input valid, color_role, title_hit, texel_x, texel_y,
                   output ready);
endinterface

// ----- design/wfpr_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window frame pixel role: decode stage
// Runs every coordinate compare of the frame geometry and registers the
// flags together with the button and texel offsets.
// ----------------------------------------------------------------------------
module wfpr_decode (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [wfpr_pkg::CoordBits-1:0] pixel_x,
   input  logic [wfpr_pkg::CoordBits-1:0] pixel_y,
   input  logic [wfpr_pkg::CoordBits-1:0] win_width,
   input  logic [wfpr_pkg::CoordBits-1:0] win_height,
   input  logic                           is_active,
   input  logic [wfpr_pkg::CoordBits-1:0] title_width,
   input  logic [wfpr_pkg::TitleBits-1:0] title_height,
   output logic                           out_valid,
   input  logic                           out_ready,
   output wfpr_pkg::decode_type           out_data
);
   import wfpr_pkg::*;

   localparam int W = CoordBits + 1;
   localparam int S = CoordBits + 2;

   logic                 valid_ff, valid_in;
   decode_type           data_ff, data_in;
   logic [W-1:0]         x_w, y_w, w_w, h_w, tw_w;
   logic signed [5:0]    ty;
   logic signed [S-1:0]  y_s, ty_s, tb_s;
   logic [CoordBits-1:0] x_off_text;

   // Widened copies so that sums and window sizes compare without wrap.
   assign x_w  = {1'b0, pixel_x};
   assign y_w  = {1'b0, pixel_y};
   assign w_w  = {1'b0, win_width};
   assign h_w  = {1'b0, win_height};
   assign tw_w = {1'b0, title_width};

   // Vertical extent of the title text box, signed because its top may
   // lie above row zero.
   assign ty   = title_top(title_height);
   assign y_s  = $signed({2'b00, pixel_y});
   assign ty_s = S'(ty);
   assign tb_s = ty_s + $signed(S'({1'b0, title_height}));
   assign x_off_text = pixel_x - CoordBits'(TextX);

   // Geometry compares.
   always_comb begin
      data_in.edge_dark    = (pixel_x == '0) || (pixel_y == '0) ||
                             (x_w + W'(1) == w_w) || (y_w + W'(1) == h_w);
      data_in.edge_high    = (pixel_x == CoordBits'(1)) || (pixel_y == CoordBits'(1));
      data_in.edge_shadow  = (x_w + W'(2) == w_w) || (y_w + W'(2) == h_w);
      data_in.span         = (pixel_x >= CoordBits'(Border)) &&
                             (x_w + W'(Border) < w_w);
      data_in.row_sep_high = (pixel_y == CoordBits'(BarH - 2));
      data_in.row_sep_dark = (pixel_y == CoordBits'(BarH - 1));
      data_in.in_close     = (pixel_x >= CoordBits'(CloseX)) &&
                             (pixel_x <  CoordBits'(CloseX + Button)) &&
                             (pixel_y >= CoordBits'(BtnY)) &&
                             (pixel_y <  CoordBits'(BtnY + Button));
      data_in.in_minimise  = (pixel_x >= CoordBits'(MinX)) &&
                             (pixel_x <  CoordBits'(MinX + Button)) &&
                             (pixel_y >= CoordBits'(BtnY)) &&
                             (pixel_y <  CoordBits'(BtnY + Button));
      data_in.in_bar       = (pixel_y >= CoordBits'(Border)) &&
                             (pixel_y <  CoordBits'(BarH - 1));
      data_in.text_box     = (title_width != '0) && (title_height != '0) &&
                             (pixel_x >= CoordBits'(TextX)) &&
                             (x_w < W'(TextX) + tw_w) &&
                             (y_s >= ty_s) && (y_s < tb_s);
      // Stripes fall on every fourth column, one past the border.
      data_in.stripe       = (pixel_x[1:0] == 2'b00);
      data_in.active       = is_active;
      data_in.close_bx     = 4'(pixel_x - CoordBits'(CloseX));
      data_in.min_bx       = 4'(pixel_x - CoordBits'(MinX));
      data_in.btn_by       = 4'(pixel_y - CoordBits'(BtnY));
      data_in.texel_x      = x_off_text;
      data_in.texel_y      = TitleBits'(y_s - ty_s);
   end

   // Stage register with back-pressure.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- design/wfpr_classify.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window frame pixel role: classify stage
// Resolves the compare flags in frame priority order into one region and
// gates the title hit and texel coordinates.
// ----------------------------------------------------------------------------
module wfpr_classify (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  wfpr_pkg::decode_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output wfpr_pkg::class_type   out_data
);
   import wfpr_pkg::*;

   logic       valid_ff, valid_in;
   class_type  data_ff, data_in;
   region_type region;
   logic       hit;

   // Edges first, then separators, buttons and the title bar.
   always_comb begin
      if (in_data.edge_dark) begin
         region = REG_DARK;
      end else if (in_data.edge_high) begin
         region = REG_HIGH;
      end else if (in_data.edge_shadow) begin
         region = REG_SHADOW;
      end else if (in_data.row_sep_high && in_data.span) begin
         region = REG_SEP_HIGH;
      end else if (in_data.row_sep_dark && in_data.span) begin
         region = REG_SEP_DARK;
      end else if (in_data.in_close) begin
         region = REG_CLOSE;
      end else if (in_data.in_minimise) begin
         region = REG_MINIMISE;
      end else if (in_data.in_bar && in_data.span) begin
         region = REG_BAR;
      end else begin
         region = REG_FACE;
      end
   end

   // Title hit only counts in the plain title bar.
   assign hit = (region == REG_BAR) && in_data.text_box;

   always_comb begin
      data_in.region  = region;
      data_in.stripe  = in_data.stripe;
      data_in.active  = in_data.active;
      data_in.bx      = in_data.in_close ? in_data.close_bx : in_data.min_bx;
      data_in.by      = in_data.btn_by;
      data_in.hit     = hit;
      data_in.texel_x = hit ? in_data.texel_x : '0;
      data_in.texel_y = hit ? in_data.texel_y : '0;
   end

   // Stage register with back-pressure.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- design/wfpr_shade.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window frame pixel role: shade stage
// Draws the button bevels and glyphs and the title stripes, then holds the
// result word in the output register.
// ----------------------------------------------------------------------------
module wfpr_shade (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  wfpr_pkg::class_type   in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output wfpr_pkg::result_type  out_data
);
   import wfpr_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;
   logic       bevel_hit;
   role_type   bevel_role, role;
   logic       glyph_cols, close_glyph, min_glyph;
   logic [3:0] bx, by;

   assign bx = in_data.bx;
   assign by = in_data.by;

   // Two-pixel bevel round each button: light on top and left.
   always_comb begin
      bevel_hit  = 1'b1;
      bevel_role = ROLE_BUTTON;
      if (bx == 4'd0 || by == 4'd0) begin
         bevel_role = ROLE_HIGH;
      end else if (bx == 4'd1 || by == 4'd1) begin
         bevel_role = ROLE_LIGHT;
      end else if (bx == 4'(BtnLast) || by == 4'(BtnLast)) begin
         bevel_role = ROLE_DARK;
      end else if (bx == 4'(BtnLast - 1) || by == 4'(BtnLast - 1)) begin
         bevel_role = ROLE_SHADOW;
      end else begin
         bevel_hit = 1'b0;
      end
   end

   // Glyphs: an X on the close button, a two-row bar on the minimise one.
   assign glyph_cols  = (bx >= 4'd4) && (bx <= 4'(BtnLast - 4));
   assign close_glyph = glyph_cols &&
                        ((bx == by) || (bx == 4'(4'(BtnLast) - by)));
   assign min_glyph   = glyph_cols && (by >= 4'(BtnLast - 4)) &&
                        (by <= 4'(BtnLast - 3));

   always_comb begin
      unique case (in_data.region)
         REG_DARK, REG_SEP_DARK: role = ROLE_DARK;
         REG_HIGH, REG_SEP_HIGH: role = ROLE_HIGH;
         REG_SHADOW:             role = ROLE_SHADOW;
         REG_CLOSE: begin
            if (bevel_hit)        role = bevel_role;
            else if (close_glyph) role = ROLE_DARK;
            else                  role = ROLE_BUTTON;
         end
         REG_MINIMISE: begin
            if (bevel_hit)        role = bevel_role;
            else if (min_glyph)   role = ROLE_DARK;
            else                  role = ROLE_BUTTON;
         end
         REG_BAR: begin
            if (in_data.stripe)
               role = in_data.active ? ROLE_STRIPE_ACTIVE : ROLE_STRIPE_INACT;
            else
               role = in_data.active ? ROLE_TITLE_ACTIVE : ROLE_TITLE_INACTIVE;
         end
         default:                role = ROLE_FACE;
      endcase
   end

   always_comb begin
      data_in.color_role = role;
      data_in.title_hit  = in_data.hit;
      data_in.texel_x    = in_data.texel_x;
      data_in.texel_y    = in_data.texel_y;
   end

   // Output register with back-pressure.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- design/window_frame_pixel_role.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window frame pixel role
// Classifies one window-local pixel into a frame colour role and reports
// title text box hits with texel coordinates.
//
//   channel   dir  word
//   req_port  in   pixel_x, pixel_y, win_width, win_height, is_active,
//                  title_width, title_height
//   rsp_port  out  color_role, title_hit, texel_x, texel_y
//
// One word is taken every clock unless a response stall holds the decode stage;
// each word passes through the decode, classify and shade registers.
// Reset clears the valid bit of every stage; payload registers are not reset.
// A stall on the response side holds each full stage in place, while empty
// stages ahead of it keep filling, so no word is lost or repeated.
// ----------------------------------------------------------------------------
module window_frame_pixel_role (
   input  logic        clock,
   input  logic        reset,
   wfpr_req_if.sink    req_port,
   wfpr_rsp_if.source  rsp_port
);
   import wfpr_pkg::*;

   logic       dec_valid, dec_ready;
   decode_type dec_data;
   logic       cls_valid, cls_ready;
   class_type  cls_data;
   result_type rsp_data;

   // Geometry compares.
   wfpr_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_port.valid),
      .in_ready     (req_port.ready),
      .pixel_x      (req_port.pixel_x),
      .pixel_y      (req_port.pixel_y),
      .win_width    (req_port.win_width),
      .win_height   (req_port.win_height),
      .is_active    (req_port.is_active),
      .title_width  (req_port.title_width),
      .title_height (req_port.title_height),
      .out_valid    (dec_valid),
      .out_ready    (dec_ready),
      .out_data     (dec_data)
   );

   // Priority decision.
   wfpr_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (cls_valid),
      .out_ready (cls_ready),
      .out_data  (cls_data)
   );

   // Button drawing, stripes and output register.
   wfpr_shade u_shade (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cls_valid),
      .in_ready  (cls_ready),
      .in_data   (cls_data),
      .out_valid (rsp_port.valid),
      .out_ready (rsp_port.ready),
      .out_data  (rsp_data)
   );

   assign rsp_port.color_role = rsp_data.color_role;
   assign rsp_port.title_hit  = rsp_data.title_hit;
   assign rsp_port.texel_x    = rsp_data.texel_x;
   assign rsp_port.texel_y    = rsp_data.texel_y;

endmodule

// ----- dv/tb_window_frame_pixel_role.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window frame pixel role: self-checking testbench
// Sends pixel words through the request channel and checks every response word,
// in order, against a predictor of the frame classification. A short table of
// directed words comes first: edges, separators, both buttons, title text, tiny
// windows and extremes. Random words follow, mostly real window geometries with
// some noise. Both channels idle in random bursts, and the response side holds
// off once for a long stretch. The tail of the run has no idling at all.
// ----------------------------------------------------------------------------
module tb_window_frame_pixel_role;
   import wfpr_pkg::*;

   // One request word as the testbench sees it.
   typedef struct {
      logic [CoordBits-1:0]  pixel_x;
      logic [CoordBits-1:0]  pixel_y;
      logic [CoordBits-1:0]  win_width;
      logic [CoordBits-1:0]  win_height;
      logic                  is_active;
      logic [CoordBits-1:0]  title_width;
      logic [TitleBits-1:0]  title_height;
   } query_type;

   // A directed row: the word, and a typed-in result where one is given.
   typedef struct {
      query_type   q;
      bit          typed;
      result_type  want;
   } row_type;

   localparam int RandomWords = 1700;
   localparam int LongHold    = 150;

   logic clock;
   logic reset;

   wfpr_req_if req_bus ();
   wfpr_rsp_if rsp_bus ();

   window_frame_pixel_role u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   result_type  role_queue[$];
   row_type     directed_rows[$];
   int          words_sent;
   int          words_checked;
   int          title_hits;
   int          failures;
   logic [9:0]  roles_seen;
   bit          idling;
   bit          long_hold;

   // Bevel of a 14x14 button, then its glyph: an X for close, a bar for minimise.
   function automatic role_type button_glyph(int bx, int by, bit is_close);
      if (bx == 0 || by == 0) return ROLE_HIGH;
      if (bx == 1 || by == 1) return ROLE_LIGHT;
      if (bx == BtnLast || by == BtnLast) return ROLE_DARK;
      if (bx == BtnLast - 1 || by == BtnLast - 1) return ROLE_SHADOW;
      if (is_close) begin
         if ((bx == by || bx == BtnLast - by) && bx >= 4 && bx <= BtnLast - 4)
            return ROLE_DARK;
      end else begin
         if (by >= BtnLast - 4 && by <= BtnLast - 3 && bx >= 4 && bx <= BtnLast - 4)
            return ROLE_DARK;
      end
      return ROLE_BUTTON;
   endfunction

   // Classification of one pixel, checked in fixed priority order with signed
   // compares, so tiny windows never match the right or bottom edge.
   function automatic result_type frame_role_of(query_type q);
      int          x, y, w, h, tw, th, top;
      role_type    role;
      result_type  r;
      x  = int'(q.pixel_x);
      y  = int'(q.pixel_y);
      w  = int'(q.win_width);
      h  = int'(q.win_height);
      tw = int'(q.title_width);
      th = int'(q.title_height);
      // Integer division truncates toward zero, so tall titles start above row 3.
      top = Border + (AreaH - th) / 2;
      r.title_hit = 1'b0;
      r.texel_x   = '0;
      r.texel_y   = '0;
      if (x == 0 || y == 0 || x == w - 1 || y == h - 1) begin
         role = ROLE_DARK;
      end else if (x == 1 || y == 1) begin
         role = ROLE_HIGH;
      end else if (x == w - 2 || y == h - 2) begin
         role = ROLE_SHADOW;
      end else if (y == BarH - 2 && x >= Border && x < w - Border) begin
         role = ROLE_HIGH;
      end else if (y == BarH - 1 && x >= Border && x < w - Border) begin
         role = ROLE_DARK;
      end else if (x >= CloseX && x < CloseX + Button && y >= BtnY && y < BtnY + Button) begin
         role = button_glyph(x - CloseX, y - BtnY, 1'b1);
      end else if (x >= MinX && x < MinX + Button && y >= BtnY && y < BtnY + Button) begin
         role = button_glyph(x - MinX, y - BtnY, 1'b0);
      end else if (y >= Border && y < BarH - 1 && x >= Border && x < w - Border) begin
         if (tw != 0 && th != 0 && x >= TextX && x < TextX + tw &&
             y >= top && y < top + th) begin
            r.title_hit = 1'b1;
            r.texel_x   = CoordBits'(x - TextX);
            r.texel_y   = TitleBits'(y - top);
         end
         if (((x - Border) & 3) == 1)
            role = q.is_active ? ROLE_STRIPE_ACTIVE : ROLE_STRIPE_INACT;
         else
            role = q.is_active ? ROLE_TITLE_ACTIVE : ROLE_TITLE_INACTIVE;
      end else begin
         role = ROLE_FACE;
      end
      r.color_role = role;
      return r;
   endfunction

   // Appends one row to the directed table.
   task automatic add_row(int x, int y, int w, int h, bit act, int tw, int th,
                          bit typed, role_type role, bit hit, int tx, int ty);
      row_type row;
      row.q.pixel_x      = CoordBits'(x);
      row.q.pixel_y      = CoordBits'(y);
      row.q.win_width    = CoordBits'(w);
      row.q.win_height   = CoordBits'(h);
      row.q.is_active    = act;
      row.q.title_width  = CoordBits'(tw);
      row.q.title_height = TitleBits'(th);
      row.typed          = typed;
      row.want.color_role = role;
      row.want.title_hit  = hit;
      row.want.texel_x    = CoordBits'(tx);
      row.want.texel_y    = TitleBits'(ty);
      directed_rows.push_back(row);
   endtask

   // Offers one word, starting and ending at a falling edge, and records the
   // expected result at the edge where the word is taken.
   task automatic send_query(query_type q, bit typed, result_type want);
      int gap;
      if (idling && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.pixel_x      <= q.pixel_x;
      req_bus.pixel_y      <= q.pixel_y;
      req_bus.win_width    <= q.win_width;
      req_bus.win_height   <= q.win_height;
      req_bus.is_active    <= q.is_active;
      req_bus.title_width  <= q.title_width;
      req_bus.title_height <= q.title_height;
      req_bus.valid        <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      role_queue.push_back(typed ? want : frame_role_of(q));
      words_sent++;
      @(negedge clock);
   endtask

   // Clock, period 4 ns.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Response side: random hold-off bursts, and one long hold-off that lets
   // the pipeline fill and push back on the request side.
   initial begin
      int hold;
      bit held_long;
      hold      = 0;
      held_long = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            hold--;
         end else if (long_hold && !held_long) begin
            held_long = 1;
            hold = LongHold - 1;
            rsp_bus.ready <= 1'b0;
         end else if (idling && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(1, 17) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Response check: every word taken is compared with the oldest expectation.
   always @(posedge clock) begin : check_rsp
      result_type got;
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.color_role = rsp_bus.color_role;
         got.title_hit  = rsp_bus.title_hit;
         got.texel_x    = rsp_bus.texel_x;
         got.texel_y    = rsp_bus.texel_y;
         if (role_queue.size() == 0) begin
            failures++;
            $display("%0t: unexpected word: role %0d hit %0d texel (%0d,%0d)",
                     $realtime, got.color_role, got.title_hit, got.texel_x, got.texel_y);
         end else begin
            want = role_queue.pop_front();
            words_checked++;
            if (got.color_role < 10)
               roles_seen[got.color_role] = 1'b1;
            if (got.title_hit === 1'b1)
               title_hits++;
            if (got.color_role !== want.color_role || got.title_hit !== want.title_hit ||
                got.texel_x !== want.texel_x || got.texel_y !== want.texel_y) begin
               failures++;
               $display({"%0t: mismatch: expected role %0d hit %0d texel (%0d,%0d),",
                         " got role %0d hit %0d texel (%0d,%0d)"},
                        $realtime, want.color_role, want.title_hit, want.texel_x,
                        want.texel_y, got.color_role, got.title_hit, got.texel_x,
                        got.texel_y);
            end
         end
      end
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Stimulus and end of run.
   initial begin
      int          n;
      int          kind;
      int          x_i, y_i, w_i, h_i, tw_i, th_i;
      query_type   q;
      result_type  none;
      none          = '0;
      words_sent    = 0;
      words_checked = 0;
      title_hits    = 0;
      failures      = 0;
      roles_seen    = '0;
      idling        = 1;
      long_hold     = 0;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.pixel_x      = '0;
      req_bus.pixel_y      = '0;
      req_bus.win_width    = '0;
      req_bus.win_height   = '0;
      req_bus.is_active    = 1'b0;
      req_bus.title_width  = '0;
      req_bus.title_height = '0;

      // Directed table: x, y, width, height, active, title w/h, then the
      // typed-in result where it is plain, else the predictor decides.
      add_row(0, 0, 4095, 4095, 1, 0, 0,        1, ROLE_DARK, 0, 0, 0);
      add_row(4095, 4095, 4095, 4095, 1, 4095, 31, 1, ROLE_FACE, 0, 0, 0);
      add_row(1, 10, 100, 100, 1, 0, 0,         1, ROLE_HIGH, 0, 0, 0);
      add_row(98, 50, 100, 100, 1, 0, 0,        1, ROLE_SHADOW, 0, 0, 0);
      add_row(99, 50, 100, 100, 1, 0, 0,        1, ROLE_DARK, 0, 0, 0);
      add_row(50, 99, 100, 100, 0, 0, 0,        1, ROLE_DARK, 0, 0, 0);
      // Separator lines win over a tall title box.
      add_row(50, 20, 100, 100, 1, 100, 31,     1, ROLE_HIGH, 0, 0, 0);
      add_row(50, 21, 100, 100, 1, 100, 31,     1, ROLE_DARK, 0, 0, 0);
      // Close button: bevel corner, centre of the X, plain face, far corner.
      add_row(5, 5, 100, 100, 1, 0, 0,         1, ROLE_HIGH, 0, 0, 0);
      add_row(12, 12, 100, 100, 1, 0, 0,       1, ROLE_DARK, 0, 0, 0);
      add_row(7, 7, 100, 100, 1, 0, 0,         0, ROLE_FACE, 0, 0, 0);
      add_row(18, 18, 100, 100, 1, 0, 0,       0, ROLE_FACE, 0, 0, 0);
      // Minimise button: bar and plain face.
      add_row(28, 14, 100, 100, 0, 0, 0,       0, ROLE_FACE, 0, 0, 0);
      add_row(24, 10, 100, 100, 0, 0, 0,       0, ROLE_FACE, 0, 0, 0);
      // Title bar: text origin, stripes, both activity states.
      add_row(42, 7, 100, 100, 1, 100, 10,     1, ROLE_TITLE_ACTIVE, 1, 0, 0);
      add_row(4, 10, 100, 100, 0, 0, 0,        1, ROLE_STRIPE_INACT, 0, 0, 0);
      add_row(45, 10, 100, 100, 0, 100, 10,    0, ROLE_FACE, 0, 0, 0);
      // Tall title whose top row lies above the title area.
      add_row(42, 3, 100, 100, 1, 100, 31,     0, ROLE_FACE, 0, 0, 0);
      add_row(4091, 10, 4095, 4095, 1, 4095, 31, 0, ROLE_FACE, 0, 0, 0);
      // Empty title in either dimension.
      add_row(42, 7, 100, 100, 1, 0, 10,       0, ROLE_FACE, 0, 0, 0);
      add_row(42, 7, 100, 100, 1, 100, 0,      0, ROLE_FACE, 0, 0, 0);
      // Tiny windows and a pixel outside the window.
      add_row(0, 0, 0, 0, 1, 0, 0,             1, ROLE_DARK, 0, 0, 0);
      add_row(2, 2, 0, 0, 1, 0, 0,             0, ROLE_FACE, 0, 0, 0);
      add_row(5, 10, 1, 1, 0, 3, 7,            0, ROLE_FACE, 0, 0, 0);
      add_row(50, 50, 100, 100, 1, 0, 0,       1, ROLE_FACE, 0, 0, 0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_query(directed_rows[i].q, directed_rows[i].typed, directed_rows[i].want);

      // Random words: mostly real window geometries aimed at the title bar and
      // buttons, with one word in ten fully random.
      for (n = 0; n < RandomWords; n++) begin
         idling = !(n >= 500 && n < 800) && n < 1400;
         if (n == 560)
            long_hold = 1;
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            x_i  = $urandom_range(0, 4095);
            y_i  = $urandom_range(0, 4095);
            w_i  = $urandom_range(0, 4095);
            h_i  = $urandom_range(0, 4095);
            tw_i = $urandom_range(0, 4095);
            th_i = $urandom_range(0, 31);
         end else begin
            if ($urandom_range(0, 9) == 0)
               w_i = $urandom_range(0, 8);
            else if ($urandom_range(0, 15) == 0)
               w_i = $urandom_range(300, 4095);
            else
               w_i = $urandom_range(40, 300);
            if ($urandom_range(0, 9) == 0)
               h_i = $urandom_range(0, 8);
            else if ($urandom_range(0, 15) == 0)
               h_i = $urandom_range(300, 4095);
            else
               h_i = $urandom_range(22, 300);
            x_i  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 64)
                                                : $urandom_range(0, w_i + 1);
            y_i  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 24)
                                                : $urandom_range(0, h_i + 1);
            tw_i = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, (w_i > 1) ? w_i : 1);
            th_i = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 31);
         end
         q.pixel_x      = CoordBits'(x_i);
         q.pixel_y      = CoordBits'(y_i);
         q.win_width    = CoordBits'(w_i);
         q.win_height   = CoordBits'(h_i);
         q.is_active    = 1'($urandom_range(0, 1));
         q.title_width  = CoordBits'(tw_i);
         q.title_height = TitleBits'(th_i);
         send_query(q, 0, none);
      end
      req_bus.valid <= 1'b0;

      // Drain, then let the pipeline run empty before reporting.
      while (role_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Run covered %0d words (%0d from the table), %0d of them title text hits.",
               words_checked, directed_rows.size(), title_hits);
      $display("Roles seen (one bit per role, face highest): %b; one long response hold-off.",
               roles_seen);
      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
